// ===== src/tdpt_pkg.sv =====
// Shared types, constants and the control program of the trial-division prime test.
package tdpt_pkg;

  // Port width of the number and its echo
  localparam int unsigned DATA_W = 32;
  // Default width of the number that is tested
  localparam int unsigned VALUE_W_DEF = 32;

  // Step counter
  localparam int unsigned PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  // Step addresses of the control program
  localparam pc_t STEP_EMIT  = 4'd0;
  localparam pc_t STEP_LOAD  = 4'd1;
  localparam pc_t STEP_CHECK = 4'd2;
  localparam pc_t STEP_SQ    = 4'd3;
  localparam pc_t STEP_CMP   = 4'd4;
  localparam pc_t STEP_DIV   = 4'd5;
  localparam pc_t STEP_TEST  = 4'd6;
  localparam pc_t STEP_LOOP  = 4'd7;
  localparam pc_t STEP_COMP  = 4'd8;
  localparam pc_t STEP_PRIME = 4'd9;

  // Datapath operations
  typedef logic [3:0] op_t;
  localparam op_t OP_NONE    = 4'd0;
  localparam op_t OP_LOAD    = 4'd1;
  localparam op_t OP_SQUARE  = 4'd2;
  localparam op_t OP_DIVINIT = 4'd3;
  localparam op_t OP_DIVSTEP = 4'd4;
  localparam op_t OP_DINC    = 4'd5;
  localparam op_t OP_CLRP    = 4'd6;
  localparam op_t OP_SETP    = 4'd7;
  localparam op_t OP_EMIT    = 4'd8;

  // Jump conditions
  typedef logic [2:0] cond_t;
  localparam cond_t C_NEVER  = 3'd0;
  localparam cond_t C_ALWAYS = 3'd1;
  localparam cond_t C_OBUSY  = 3'd2;
  localparam cond_t C_NOIN   = 3'd3;
  localparam cond_t C_LT2    = 3'd4;
  localparam cond_t C_SQGT   = 3'd5;
  localparam cond_t C_MORE   = 3'd6;
  localparam cond_t C_REMZ   = 3'd7;

  // One control word
  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } uword_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic lt2;
    logic sq_gt;
    logic more;
    logic rem_zero;
  } flags_t;

  // Control program
  function automatic uword_t ucode(input pc_t pc);
    uword_t w;
    w = '{op: OP_NONE, cond: C_ALWAYS, target: STEP_LOAD};
    unique case (pc)
      STEP_EMIT:  w = '{op: OP_EMIT,    cond: C_OBUSY,  target: STEP_EMIT};
      STEP_LOAD:  w = '{op: OP_LOAD,    cond: C_NOIN,   target: STEP_LOAD};
      STEP_CHECK: w = '{op: OP_NONE,    cond: C_LT2,    target: STEP_COMP};
      STEP_SQ:    w = '{op: OP_SQUARE,  cond: C_NEVER,  target: STEP_SQ};
      STEP_CMP:   w = '{op: OP_DIVINIT, cond: C_SQGT,   target: STEP_PRIME};
      STEP_DIV:   w = '{op: OP_DIVSTEP, cond: C_MORE,   target: STEP_DIV};
      STEP_TEST:  w = '{op: OP_DINC,    cond: C_REMZ,   target: STEP_COMP};
      STEP_LOOP:  w = '{op: OP_NONE,    cond: C_ALWAYS, target: STEP_SQ};
      STEP_COMP:  w = '{op: OP_CLRP,    cond: C_ALWAYS, target: STEP_EMIT};
      STEP_PRIME: w = '{op: OP_SETP,    cond: C_ALWAYS, target: STEP_EMIT};
      default:    w = '{op: OP_NONE,    cond: C_ALWAYS, target: STEP_LOAD};
    endcase
    return w;
  endfunction

endpackage

// ===== src/trial_division_prime_test.sv =====
// Trial-division prime test: a microcoded sequencer over a shift-subtract datapath.
// Values below 2 are composite at once; else each divisor tried takes the steps square,
// compare, VALUE_W remainder steps, test and loop (2, then odd ones while the square is at
// most the value); the word is composite when a divisor divides, and prime once the square
// passes the value. Throughput: one word at a time; the next word is taken while the result
// waits in the output register. Reset: async, active low.
module trial_division_prime_test #(
  parameter int unsigned VALUE_W = tdpt_pkg::VALUE_W_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [tdpt_pkg::DATA_W-1:0] candidate_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [tdpt_pkg::DATA_W-1:0] candidate_echo_o,
  output logic                              is_prime_o
);
  import tdpt_pkg::*;

  pc_t                 pc_q, pc_d;
  uword_t              uw;
  flags_t              flags;
  logic                jump;
  logic                take;
  logic                out_busy;
  logic                verdict_q, verdict_d;
  logic                out_valid_q, out_valid_d;
  logic [DATA_W-1:0]   echo_q, echo_d;
  logic                prime_q, prime_d;
  logic [VALUE_W-1:0]  cand;

  assign uw         = ucode(pc_q);
  assign in_stall_o = (pc_q != STEP_LOAD);
  assign take       = in_valid_i & ~in_stall_o;
  assign out_busy   = out_valid_q & out_stall_i;

  tdpt_dpath #(
    .VALUE_W (VALUE_W)
  ) u_dpath (
    .clk_i   (clk_i),
    .op_i    (uw.op),
    .take_i  (take),
    .cand_i  (candidate_i[VALUE_W-1:0]),
    .cand_o  (cand),
    .flags_o (flags)
  );

  // Evaluate the jump condition of the current control word
  always_comb begin
    unique case (uw.cond)
      C_NEVER:  jump = 1'b0;
      C_ALWAYS: jump = 1'b1;
      C_OBUSY:  jump = out_busy;
      C_NOIN:   jump = ~in_valid_i;
      C_LT2:    jump = flags.lt2;
      C_SQGT:   jump = flags.sq_gt;
      C_MORE:   jump = flags.more;
      C_REMZ:   jump = flags.rem_zero;
      default:  jump = 1'b0;
    endcase
    pc_d = jump ? uw.target : pc_q + PC_W'(1);
  end

  // Set or hold the verdict, and load, hold or clear the output register
  always_comb begin
    verdict_d   = verdict_q;
    out_valid_d = out_valid_q;
    echo_d      = echo_q;
    prime_d     = prime_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (uw.op)
      OP_CLRP: verdict_d = 1'b0;
      OP_SETP: verdict_d = 1'b1;
      OP_EMIT: begin
        if (!out_busy) begin
          out_valid_d = 1'b1;
          echo_d      = DATA_W'($signed(cand));
          prime_d     = verdict_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= STEP_LOAD;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    verdict_q <= verdict_d;
    echo_q    <= echo_d;
    prime_q   <= prime_d;
  end

  assign out_valid_o      = out_valid_q;
  assign candidate_echo_o = echo_q;
  assign is_prime_o       = prime_q;

endmodule

// ===== src/tdpt_dpath.sv =====
// Datapath: number register, divisor, square and a one-bit-per-cycle remainder unit.
module tdpt_dpath #(
  parameter int unsigned VALUE_W = tdpt_pkg::VALUE_W_DEF
) (
  input  logic                clk_i,
  input  tdpt_pkg::op_t       op_i,
  input  logic                take_i,
  input  logic [VALUE_W-1:0]  cand_i,
  output logic [VALUE_W-1:0]  cand_o,
  output tdpt_pkg::flags_t    flags_o
);
  import tdpt_pkg::*;

  localparam int unsigned DW  = VALUE_W / 2 + 1;
  localparam int unsigned SQW = 2 * DW;
  localparam int unsigned CW  = $clog2(VALUE_W);

  logic [VALUE_W-1:0] cand_q, cand_d;
  logic [DW-1:0]      div_q, div_d;
  logic [SQW-1:0]     sq_q, sq_d;
  logic [DW-1:0]      rem_q, rem_d;
  logic [VALUE_W-1:0] sh_q, sh_d;
  logic [CW-1:0]      cnt_q, cnt_d;

  logic [DW:0]        trial;
  logic [DW:0]        div_ext;
  logic [DW:0]        diff;

  // Shift in the next dividend bit and subtract the divisor if it fits
  assign trial   = {rem_q, sh_q[VALUE_W-1]};
  assign div_ext = {1'b0, div_q};
  assign diff    = trial - div_ext;

  always_comb begin
    cand_d = cand_q;
    div_d  = div_q;
    sq_d   = sq_q;
    rem_d  = rem_q;
    sh_d   = sh_q;
    cnt_d  = cnt_q;
    case (op_i)
      OP_LOAD: begin
        if (take_i) begin
          cand_d = cand_i;
          div_d  = DW'(2);
        end
      end
      OP_SQUARE: begin
        sq_d = {{DW{1'b0}}, div_q} * {{DW{1'b0}}, div_q};
      end
      OP_DIVINIT: begin
        rem_d = '0;
        sh_d  = cand_q;
        cnt_d = CW'(VALUE_W - 1);
      end
      OP_DIVSTEP: begin
        rem_d = (trial >= div_ext) ? diff[DW-1:0] : trial[DW-1:0];
        sh_d  = sh_q << 1;
        cnt_d = cnt_q - CW'(1);
      end
      OP_DINC: begin
        // After two, step through odd divisors only
        div_d = div_q + (div_q[0] ? DW'(2) : DW'(1));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    cand_q <= cand_d;
    div_q  <= div_d;
    sq_q   <= sq_d;
    rem_q  <= rem_d;
    sh_q   <= sh_d;
    cnt_q  <= cnt_d;
  end

  // Status toward the sequencer
  assign flags_o.lt2      = cand_q[VALUE_W-1] | (cand_q[VALUE_W-1:1] == '0);
  assign flags_o.sq_gt    = sq_q > {{(SQW-VALUE_W){1'b0}}, cand_q};
  assign flags_o.more     = (cnt_q != '0);
  assign flags_o.rem_zero = (rem_q == '0);
  assign cand_o           = cand_q;

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the trial-division prime test block.
module tb_top;
  import tdpt_pkg::*;

  // Tested width; the predictor uses the same value as the block
  localparam int unsigned VAL_W = VALUE_W_DEF;
  localparam int unsigned N_DIRECTED = 21;
  localparam int unsigned N_RANDOM = 80;
  // Random words kept small up front so the output hold-off fills the block
  localparam int unsigned N_SMALL_LEAD = 12;
  localparam int unsigned PRESSURE_AT = N_DIRECTED + 3;
  localparam int unsigned PRESSURE_CYCLES = 2000;
  localparam int unsigned DRAIN_CYCLES = 60;
  // A 31-bit prime ties up the block with nothing moving
  localparam int unsigned QUIET_LIMIT = 4_000_000;

  typedef struct packed {
    logic [DATA_W-1:0] echo;
    logic              prime;
  } verdict_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              typed;
    logic              prime;
  } stim_row_t;

  logic                     clk_i;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic signed [DATA_W-1:0] candidate_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [DATA_W-1:0] candidate_echo_o;
  logic                     is_prime_o;

  verdict_t    pending_verdicts[$];
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;

  // Directed words: expected verdict typed in where it is obvious
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{32'h0000_0000, 1'b1, 1'b0},  // zero
    '{32'h0000_0001, 1'b1, 1'b0},  // one
    '{32'hFFFF_FFFF, 1'b1, 1'b0},  // minus one
    '{32'hFFFF_FFFE, 1'b1, 1'b0},  // minus two
    '{32'h8000_0000, 1'b1, 1'b0},  // most negative
    '{32'hAAAA_AAAA, 1'b1, 1'b0},  // negative, alternating bits
    '{32'h0000_0002, 1'b1, 1'b1},  // smallest prime
    '{32'h0000_0003, 1'b1, 1'b1},
    '{32'h0000_0004, 1'b1, 1'b0},
    '{32'h7FFF_FFFE, 1'b1, 1'b0},  // largest even
    '{32'd9,         1'b0, 1'b0},  // square of a prime, divisor equals root
    '{32'd25,        1'b0, 1'b0},
    '{32'd121,       1'b0, 1'b0},
    '{32'd97,        1'b0, 1'b0},
    '{32'd65521,     1'b0, 1'b0},
    '{32'd65537,     1'b0, 1'b0},
    '{32'd1042441,   1'b0, 1'b0},  // 1021 squared: walks to the root
    '{32'h5555_5555, 1'b0, 1'b0},
    '{32'h4000_0000, 1'b0, 1'b0},
    '{32'h7FFF_FFFD, 1'b0, 1'b0},
    '{32'h7FFF_FFFF, 1'b1, 1'b1}   // largest value, prime: squares pass 2^31
  };

  trial_division_prime_test #(
    .VALUE_W(VAL_W)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .candidate_i     (candidate_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .candidate_echo_o(candidate_echo_o),
    .is_prime_o      (is_prime_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Sign-extend the tested bits and run trial division at full width
  function automatic verdict_t prime_verdict(input logic [DATA_W-1:0] raw);
    verdict_t                 v;
    logic signed [DATA_W-1:0] shifted;
    longint                   value;
    longint unsigned          n;
    longint unsigned          d;
    shifted = raw << (DATA_W - VAL_W);
    value = longint'(shifted >>> (DATA_W - VAL_W));
    v.echo = value[DATA_W-1:0];
    v.prime = 1'b0;
    if (value >= 2) begin
      n = longint'(value);
      v.prime = 1'b1;
      for (d = 2; d * d <= n; d = d + 1) begin
        if (n % d == 0) begin
          v.prime = 1'b0;
          break;
        end
      end
    end
    return v;
  endfunction

  // Pick a random candidate; keep slow primes rare so the run stays short
  function automatic logic [DATA_W-1:0] draw_candidate(input bit small_only);
    logic [DATA_W-1:0] v;
    int unsigned       kind;
    int unsigned       root;
    kind = small_only ? 0 : $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3: begin
        v = $urandom_range(0, 2000);
      end
      4: begin
        v = $urandom_range(2001, 1 << 20);
      end
      5: begin
        v = {1'b1, 31'($urandom)};
      end
      6: begin
        v = $urandom & 32'h7FFF_FFFE;
      end
      7: begin
        v = $urandom_range(1, 715827882) * 3;
      end
      8: begin
        // near a perfect square
        root = $urandom_range(2, 300);
        v = root * root + $urandom_range(0, 2) - 1;
      end
      default: begin
        // any bits; large positives forced even so they resolve fast
        v = $urandom;
        if (!v[DATA_W-1] && v > 32'h000F_FFFF) v[0] = 1'b0;
      end
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    $display("MISMATCH %s: got %h, expected %h", what, got, want);
    mismatch_count++;
  endtask

  // Offer one word after a random gap (none in a burst), hold it until taken, then queue its verdict
  task automatic send_word(input logic [DATA_W-1:0] value, input logic typed,
                           input logic typed_prime, input bit burst);
    int unsigned gap;
    verdict_t    want;
    gap = burst ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    candidate_i <= value;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    want = prime_verdict(value);
    if (typed) want.prime = typed_prime;
    pending_verdicts.push_back(want);
  endtask

  // Stimulus, drain and verdict
  initial begin
    bit burst;
    burst = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int r = 0; r < N_DIRECTED; r++) begin
      if (r % 7 == 0) burst = ($urandom_range(0, 2) == 0);
      send_word(directed_rows[r].value, directed_rows[r].typed, directed_rows[r].prime,
                burst);
    end
    for (int k = 0; k < N_RANDOM; k++) begin
      if (k % 10 == 0) burst = ($urandom_range(0, 3) == 0);
      send_word(draw_candidate(k < N_SMALL_LEAD), 1'b0, 1'b0, burst);
    end
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Take results with random stalls and one long hold-off; check each word
  initial begin
    verdict_t    want;
    int unsigned results_seen;
    int unsigned hold;
    bit          burst;
    results_seen = 0;
    burst = 1'b0;
    forever begin
      if (results_seen == PRESSURE_AT) begin
        out_stall_i <= 1'b1;
        repeat (PRESSURE_CYCLES) @(posedge clk_i);
      end else begin
        if (results_seen % 10 == 0) burst = ($urandom_range(0, 3) == 0);
        hold = burst ? 0 : $urandom_range(0, 7);
        if (hold != 0) begin
          out_stall_i <= 1'b1;
          repeat (hold) @(posedge clk_i);
        end
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      results_seen++;
      if (pending_verdicts.size() == 0) begin
        report_mismatch("unexpected word", candidate_echo_o, '0);
      end else begin
        want = pending_verdicts.pop_front();
        if (candidate_echo_o !== want.echo)
          report_mismatch("candidate_echo", candidate_echo_o, want.echo);
        if (is_prime_o !== want.prime)
          report_mismatch("is_prime", DATA_W'(is_prime_o), DATA_W'(want.prime));
      end
    end
  end

  // Watchdog: end the run when no word moves on either side for too long
  initial begin
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("TIMEOUT: no word accepted in %0d cycles", QUIET_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== trial_division_prime_test.f =====
src/tdpt_pkg.sv
src/tdpt_dpath.sv
src/trial_division_prime_test.sv
verif/tb_top.sv
